/* design/assert_macros.svh */
// Assertion macros shared by the divisor count and sum block.
// Every assertion is clocked on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define DCS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define DCS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/dcs_pkg.sv */
// Package for the divisor count and sum block: widths, unit op codes and
// the control/status structs between the sequencer and the shared unit.
// No dependencies.
`default_nettype none

package dcs_pkg;

  // Width of the value to factor.
  localparam int VALUE_BITS = 31;
  // Result widths.
  localparam int COUNT_BITS = 12;
  localparam int SUM_BITS   = 34;
  // Trial divisor never exceeds sqrt(2^VALUE_BITS) + 2.
  localparam int D_BITS     = (VALUE_BITS + 1) / 2 + 1;
  // Multiplier operand: holds n + 1 and the geometric sum of a prime power.
  localparam int ARG_BITS   = VALUE_BITS + 1;
  // Exponent of a prime power.
  localparam int K_BITS     = $clog2(VALUE_BITS + 1);
  // Step counter of the shared unit.
  localparam int STEP_BITS  = $clog2(ARG_BITS + 1);

  // Shared unit operations.
  localparam logic ALU_OP_DIV = 1'b0;
  localparam logic ALU_OP_MUL = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

endpackage

`default_nettype wire

/* design/dcs_alu.sv */
// Shared shift/add-subtract unit: restoring divide or shift-add multiply,
// one bit per cycle. Depends on dcs_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module dcs_alu import dcs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire alu_req_t              req,
  input  wire logic [SUM_BITS-1:0]   opa_in,
  input  wire logic [ARG_BITS-1:0]   opb_in,
  output alu_stat_t                  stat,
  output logic      [VALUE_BITS-1:0] quotient,
  output logic      [D_BITS-1:0]     remainder,
  output logic      [SUM_BITS-1:0]   product
);

  logic                 busy;
  logic                 done;
  logic                 op;
  logic [STEP_BITS-1:0] steps;
  logic [SUM_BITS-1:0]  acc;
  logic [SUM_BITS-1:0]  opa;
  logic [ARG_BITS-1:0]  opb;

  logic                 is_div;
  logic [SUM_BITS-1:0]  lhs;
  logic [SUM_BITS-1:0]  addend;
  logic [SUM_BITS:0]    total;
  logic                 fits;

  // One adder: acc + opa for multiply, shifted remainder - divisor for divide
  assign is_div = (op == ALU_OP_DIV);
  assign lhs    = is_div ? {acc[SUM_BITS-2:0], opb[VALUE_BITS-1]} : acc;
  assign addend = is_div ? ~opa : opa;
  assign total  = {1'b0, lhs} + {1'b0, addend} + {{SUM_BITS{1'b0}}, is_div};
  assign fits   = total[SUM_BITS];

  // Control: busy while the step counter runs down, then a one-cycle done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && steps == STEP_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      op    <= req.op;
      acc   <= '0;
      opa   <= opa_in;
      opb   <= opb_in;
      steps <= (req.op == ALU_OP_DIV) ? STEP_BITS'(VALUE_BITS) : STEP_BITS'(ARG_BITS);
    end else if (busy) begin
      steps <= steps - STEP_BITS'(1);
      if (is_div) begin
        acc <= fits ? total[SUM_BITS-1:0] : lhs;
        opb <= {opb[ARG_BITS-2:0], fits};
      end else begin
        if (opb[0]) begin
          acc <= total[SUM_BITS-1:0];
        end
        opa <= {opa[SUM_BITS-2:0], 1'b0};
        opb <= {1'b0, opb[ARG_BITS-1:1]};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = opb[VALUE_BITS-1:0];
  assign remainder = acc[D_BITS-1:0];
  assign product   = acc;

  `DCS_ASSERT(a_no_restart, req.start |-> !busy, "unit started while busy")
  `DCS_ASSERT_NEXT(a_start_busy, req.start, busy, "unit not busy after start")
  `DCS_ASSERT(a_done_idle, done |-> !busy, "done raised while still busy")

endmodule

`default_nettype wire

/* design/divisor_count_and_sum.sv */
// Divisor count and sum by trial division over 2, 3, 5, 7, ...
// Each trial divisor costs one divide in the shared unit; each prime power
// found adds a multiply. One request at a time; the next is taken after the
// result is loaded into the output register. Sync reset clears control only.
`default_nettype none

`include "assert_macros.svh"

module divisor_count_and_sum import dcs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic                  value_valid,
  output logic                       value_stall,
  output logic      [COUNT_BITS-1:0] divisor_count,
  output logic      [SUM_BITS-1:0]   divisor_sum,
  output logic                       result_valid,
  input  wire logic                  result_stall
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DIV_GO    = 4'd1;
  localparam logic [3:0] S_DIV_WAIT  = 4'd2;
  localparam logic [3:0] S_PW_GO     = 4'd3;
  localparam logic [3:0] S_PW_WAIT   = 4'd4;
  localparam logic [3:0] S_SUM_GO    = 4'd5;
  localparam logic [3:0] S_SUM_WAIT  = 4'd6;
  localparam logic [3:0] S_TAIL      = 4'd7;
  localparam logic [3:0] S_TAIL_GO   = 4'd8;
  localparam logic [3:0] S_TAIL_WAIT = 4'd9;
  localparam logic [3:0] S_DONE      = 4'd10;

  logic [3:0]            state;
  logic                  factor;
  logic [VALUE_BITS-1:0] n;
  logic [D_BITS-1:0]     d;
  logic [COUNT_BITS-1:0] cnt;
  logic [SUM_BITS-1:0]   sum;
  logic [K_BITS-1:0]     k;
  logic [VALUE_BITS-1:0] pw;
  logic [ARG_BITS-1:0]   geo;

  alu_req_t              alu_req;
  alu_stat_t             alu_stat;
  logic [SUM_BITS-1:0]   alu_a;
  logic [ARG_BITS-1:0]   alu_b;
  logic [VALUE_BITS-1:0] alu_quot;
  logic [D_BITS-1:0]     alu_rem;
  logic [SUM_BITS-1:0]   alu_prod;

  logic [D_BITS-1:0]     d_next;
  logic [K_BITS:0]       k_inc;
  logic [COUNT_BITS-1:0] cnt_scaled;
  logic                  in_wait;

  assign value_stall = (state != S_IDLE);

  // Small bookkeeping
  assign d_next     = (d == D_BITS'(2)) ? D_BITS'(3) : d + D_BITS'(2);
  assign k_inc      = {1'b0, k} + (K_BITS + 1)'(1);
  assign cnt_scaled = cnt * COUNT_BITS'(k_inc);

  // Operand selection for the shared unit
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = ALU_OP_DIV;
    alu_a         = SUM_BITS'(d);
    alu_b         = ARG_BITS'(n);
    unique case (state)
      S_DIV_GO: begin
        alu_req.start = 1'b1;
      end
      S_PW_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_OP_MUL;
        alu_a         = SUM_BITS'(pw);
        alu_b         = ARG_BITS'(d);
      end
      S_SUM_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_OP_MUL;
        alu_a         = sum;
        alu_b         = geo;
      end
      S_TAIL_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_OP_MUL;
        alu_a         = sum;
        alu_b         = {1'b0, n} + ARG_BITS'(1);
      end
      default: begin
      end
    endcase
  end

  dcs_alu u_alu (
    .clk       (clk),
    .rst       (rst),
    .req       (alu_req),
    .opa_in    (alu_a),
    .opb_in    (alu_b),
    .stat      (alu_stat),
    .quotient  (alu_quot),
    .remainder (alu_rem),
    .product   (alu_prod)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      factor       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // output register drains on accept unless a new result loads now
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (value_valid) begin
            n      <= value;
            d      <= D_BITS'(2);
            cnt    <= COUNT_BITS'(1);
            sum    <= SUM_BITS'(1);
            factor <= 1'b0;
            state  <= S_DIV_GO;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (alu_stat.done) begin
            if (!factor) begin
              // d > n / d means d * d > n: trial divisors used up
              if (VALUE_BITS'(d) > alu_quot) begin
                state <= S_TAIL;
              end else if (alu_rem == '0) begin
                n      <= alu_quot;
                k      <= K_BITS'(1);
                pw     <= VALUE_BITS'(d);
                geo    <= ARG_BITS'(d) + ARG_BITS'(1);
                factor <= 1'b1;
                state  <= S_DIV_GO;
              end else begin
                d     <= d_next;
                state <= S_DIV_GO;
              end
            end else if (alu_rem == '0) begin
              // one more power of the same prime
              n     <= alu_quot;
              k     <= k_inc[K_BITS-1:0];
              state <= S_PW_GO;
            end else begin
              cnt    <= cnt_scaled;
              factor <= 1'b0;
              state  <= S_SUM_GO;
            end
          end
        end
        S_PW_GO: state <= S_PW_WAIT;
        S_PW_WAIT: begin
          if (alu_stat.done) begin
            pw    <= alu_prod[VALUE_BITS-1:0];
            geo   <= geo + ARG_BITS'(alu_prod[VALUE_BITS-1:0]);
            state <= S_DIV_GO;
          end
        end
        S_SUM_GO: state <= S_SUM_WAIT;
        S_SUM_WAIT: begin
          if (alu_stat.done) begin
            sum   <= alu_prod;
            d     <= d_next;
            state <= S_DIV_GO;
          end
        end
        S_TAIL: begin
          // leftover factor above one is prime
          if (n > VALUE_BITS'(1)) begin
            cnt   <= {cnt[COUNT_BITS-2:0], 1'b0};
            state <= S_TAIL_GO;
          end else begin
            state <= S_DONE;
          end
        end
        S_TAIL_GO: state <= S_TAIL_WAIT;
        S_TAIL_WAIT: begin
          if (alu_stat.done) begin
            sum   <= alu_prod;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            divisor_count <= cnt;
            divisor_sum   <= sum;
            result_valid  <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // States that wait on the shared unit
  assign in_wait = (state == S_DIV_WAIT) || (state == S_PW_WAIT) ||
                   (state == S_SUM_WAIT) || (state == S_TAIL_WAIT);

  `DCS_ASSERT(a_done_in_wait, alu_stat.done |-> in_wait, "unit done outside a wait state")
  `DCS_ASSERT(a_factor_k, (factor && state != S_IDLE) |-> (k != '0), "prime power with zero exponent")
  `DCS_ASSERT(a_cnt_nonzero, (state != S_IDLE) |-> (cnt != '0), "divisor count dropped to zero")

endmodule

`default_nettype wire

/* test/tb_divisor_count_and_sum.sv */
// Self-checking bench for divisor_count_and_sum: corner values, then random values
// that factor quickly, checked against a divisor count/sum predictor in the bench.
// Depends on dcs_pkg and divisor_count_and_sum.
`timescale 1ns / 100ps

module tb_divisor_count_and_sum;
  import dcs_pkg::*;

  // 2^31-1 is prime, so its trial division runs up to its square root
  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int unsigned RANDOM_ITEMS = 77;
  localparam int unsigned HOLD_AT_RESULT = 40;
  localparam int unsigned HOLD_CYCLES = 12_000;
  localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 1;

  typedef struct packed {
    logic [COUNT_BITS-1:0] dcount;
    logic [SUM_BITS-1:0]   dsum;
  } divisor_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [VALUE_BITS-1:0] value = '0;
  logic value_valid = 1'b0;
  logic value_stall;
  logic [COUNT_BITS-1:0] divisor_count;
  logic [SUM_BITS-1:0] divisor_sum;
  logic result_valid;
  logic result_stall;

  logic [VALUE_BITS-1:0] pending_values[$];
  divisor_pair_t divisor_results_due[$];

  int unsigned send_gap = 0;
  int unsigned sink_wait = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  divisor_count_and_sum u_top (
    .clk          (clk),
    .rst          (rst),
    .value        (value),
    .value_valid  (value_valid),
    .value_stall  (value_stall),
    .divisor_count(divisor_count),
    .divisor_sum  (divisor_sum),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Trial division over 2, 3, 5, 7, ... with prime-power bookkeeping
  function automatic divisor_pair_t factor_divisors(input logic [VALUE_BITS-1:0] n_in);
    longint unsigned n, cnt, total, d, pw, geo, k;
    divisor_pair_t r;
    n = n_in;
    cnt = 1;
    total = 1;
    d = 2;
    while (d * d <= n) begin
      if (n % d == 0) begin
        k = 0;
        pw = 1;
        geo = 1;
        while (n % d == 0) begin
          n = n / d;
          k++;
          pw = pw * d;
          geo = geo + pw;
        end
        cnt = cnt * (k + 1);
        total = total * geo;
      end
      d = (d == 2) ? 3 : d + 2;
    end
    // leftover factor is a prime
    if (n > 1) begin
      cnt = cnt * 2;
      total = total * (n + 1);
    end
    r.dcount = cnt[COUNT_BITS-1:0];
    r.dsum = total[SUM_BITS-1:0];
    return r;
  endfunction

  // Every third stretch of 16 results runs with no idling on either side
  function automatic int unsigned pick_wait();
    return ((results_seen / 16) % 3 == 2) ? 0 : $urandom_range(0, 7);
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endtask

  // Request driver
  always @(posedge clk) begin : request_driver
    int unsigned gap_draw;
    if (rst) begin
      value_valid <= 1'b0;
      send_gap <= 0;
    end else if (value_valid && !value_stall) begin
      divisor_results_due = {divisor_results_due, factor_divisors(value)};
      gap_draw = pick_wait();
      if (gap_draw == 0 && pending_values.size() != 0) begin
        value <= pending_values.pop_front();
      end else begin
        value_valid <= 1'b0;
        send_gap <= gap_draw;
      end
    end else if (!value_valid) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_values.size() != 0) begin
        value <= pending_values.pop_front();
        value_valid <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin : result_checker
    divisor_pair_t want;
    if (rst) begin
      sink_wait <= 0;
    end else if (result_valid && !result_stall) begin
      results_seen <= results_seen + 1;
      if (divisor_results_due.size() == 0) begin
        report_mismatch($sformatf("result count=%0d sum=%0d with no request outstanding",
                                  divisor_count, divisor_sum));
      end else begin
        want = divisor_results_due.pop_front();
        if (divisor_count !== want.dcount)
          report_mismatch($sformatf("divisor_count got %0d want %0d",
                                    divisor_count, want.dcount));
        if (divisor_sum !== want.dsum)
          report_mismatch($sformatf("divisor_sum got %0d want %0d",
                                    divisor_sum, want.dsum));
      end
      sink_wait <= pick_wait();
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
    end
  end

  // One long output hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen == HOLD_AT_RESULT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  assign result_stall = (sink_wait != 0) || (hold_left != 0);

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus and end of test
  initial begin : stimulus
    int unsigned corner_values[] = '{
      0, 1, 2, 3, 4, 8, 9, 12, 25, 36, 49, 97, 360, 65521, 65536, 131042,
      720720, 223092870, 735134400, 1073741824, 1162261467, 2147483646,
      2147483647
    };
    int unsigned small_primes[] = '{
      2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61,
      67, 71, 73, 79, 83, 89, 97
    };
    longint unsigned n;
    int unsigned p, kind;

    foreach (corner_values[i])
      pending_values = {pending_values, VALUE_BITS'(corner_values[i])};

    // random values kept cheap to factor: small, smooth, or small times 2^s
    repeat (RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        n = $urandom_range(0, 65535);
      end else if (kind < 7) begin
        n = 1;
        repeat ($urandom_range(1, 12)) begin
          p = small_primes[$urandom_range(0, small_primes.size() - 1)];
          if (n * p <= VALUE_MAX) n = n * p;
        end
      end else begin
        n = (longint'($urandom_range(1, 65535)) << $urandom_range(0, 15)) & VALUE_MAX;
      end
      pending_values = {pending_values, VALUE_BITS'(n)};
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_values.size() != 0 || value_valid || divisor_results_due.size() != 0);
    repeat (100) @(negedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/dcs_pkg.sv
design/dcs_alu.sv
design/divisor_count_and_sum.sv
test/tb_divisor_count_and_sum.sv
